### design/luma_background_subtraction_macros.svh
// assertion macros shared by the checker of the luma background subtraction block
`ifndef LUMA_BACKGROUND_SUBTRACTION_MACROS_SVH
`define LUMA_BACKGROUND_SUBTRACTION_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define LBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is asserted
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lbs_pkg.sv
// shared types and constants of the luma background subtraction block
package lbs_pkg;

	// operation codes carried in the input tuser
	localparam logic OP_DETECT = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// configuration register indexes
	localparam int          CFG_ADDR_W    = 2;
	localparam int          CFG_DATA_W    = 11;
	localparam logic [1:0]  CFG_THRESHOLD = 2'd0;
	localparam logic [1:0]  CFG_WIDTH     = 2'd1;
	localparam logic [1:0]  CFG_HEIGHT    = 2'd2;

	// register widths and reset values
	localparam int          THRESH_W      = 8;
	localparam int          FWIDTH_W      = 11;
	localparam int          FHEIGHT_W     = 10;
	localparam logic [7:0]  THRESH_RST    = 8'd30;
	localparam logic [10:0] FWIDTH_RST    = 11'd640;
	localparam logic [9:0]  FHEIGHT_RST   = 10'd480;

	// field widths
	localparam int LUMA_W   = 8;
	localparam int TALLY_W  = 20;
	localparam int FRAMES_W = 32;
	localparam int IN_DW    = 24;
	localparam int OUT_DW   = 64;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	// luma weights, scaled by 2^16 (they sum to 2^16)
	localparam int       LUMA_SUM_W = 24;
	localparam logic [15:0] COEF_R = 16'd19595;
	localparam logic [15:0] COEF_G = 16'd38470;
	localparam logic [15:0] COEF_B = 16'd7471;

	// configuration seen by the front and back parts
	typedef struct packed {
		logic [THRESH_W-1:0]  threshold;
		logic [FWIDTH_W-1:0]  frame_width;
		logic [FHEIGHT_W-1:0] frame_height;
	} lbs_cfg_t;

	// word handed from the front part to the back part
	typedef struct packed {
		logic              op;
		logic [LUMA_W-1:0] luma;
		logic [LUMA_W-1:0] bg;
		logic              frame_end;
	} lbs_item_t;

endpackage

### design/luma_background_subtraction.sv
// Luma background subtraction: BGR pixels in raster order, one word per clock. Each pixel
// becomes 8-bit luma; a load word stores it as background at the current raster position,
// a detect word flags it as moving when it differs from the stored background by more than
// the threshold, and tallies moving pixels per frame and completed detect frames. The block
// sustains one pixel per clock once clearing is over and while m_tready is held high; a pixel
// passes the input register, luma and background store port, queue and output register in
// turn. After reset the background store is cleared one entry per clock, MAX_WIDTH*MAX_HEIGHT
// entries (524288 with the defaults), while s_tready stays low; configuration writes are taken meanwhile.
module luma_background_subtraction #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [lbs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [lbs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// pixel input
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lbs_pkg::IN_DW-1:0]          s_tdata,  // blue, green, red
	input  logic                               s_tuser,  // operation
	// result output
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lbs_pkg::OUT_DW-1:0]         m_tdata,  // moving, luma, frame_detections,
	                                                     // frames_done, zero fill
	output logic                               m_tlast   // frame_end
);

	lbs_pkg::lbs_cfg_t  cfg_q;
	lbs_pkg::lbs_item_t front_item;
	lbs_pkg::lbs_item_t back_item;
	logic               front_valid;
	logic               front_ready;
	logic               back_valid;
	logic               back_ready;
	logic               out_moving;
	logic [7:0]         out_luma;
	logic [19:0]        out_detections;
	logic [31:0]        out_frames_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= lbs_pkg::THRESH_RST;
			cfg_q.frame_width  <= lbs_pkg::FWIDTH_RST;
			cfg_q.frame_height <= lbs_pkg::FHEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lbs_pkg::CFG_THRESHOLD: cfg_q.threshold    <= cfg_wdata[lbs_pkg::THRESH_W-1:0];
				lbs_pkg::CFG_WIDTH:     cfg_q.frame_width  <= cfg_wdata[lbs_pkg::FWIDTH_W-1:0];
				lbs_pkg::CFG_HEIGHT:    cfg_q.frame_height <= cfg_wdata[lbs_pkg::FHEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	lbs_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_blue    (s_tdata[7:0]),
		.in_green   (s_tdata[15:8]),
		.in_red     (s_tdata[23:16]),
		.item_valid (front_valid),
		.item_ready (front_ready),
		.item       (front_item)
	);

	lbs_fifo #(
		.DEPTH (4)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	lbs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.item_valid      (back_valid),
		.item_ready      (back_ready),
		.item            (back_item),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_moving      (out_moving),
		.out_luma        (out_luma),
		.out_detections  (out_detections),
		.out_frame_end   (m_tlast),
		.out_frames_done (out_frames_done)
	);

	// output word packing, lowest field first
	assign m_tdata = {3'b000, out_frames_done, out_detections, out_luma, out_moving};

endmodule

### design/lbs_front.sv
// front part: pixel intake, raster position, luma and background store access
module lbs_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 512
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lbs_pkg::lbs_cfg_t         cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      in_op,
	input  logic [7:0]                in_blue,
	input  logic [7:0]                in_green,
	input  logic [7:0]                in_red,
	output logic                      item_valid,
	input  logic                      item_ready,
	output lbs_pkg::lbs_item_t        item
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int PW    = WW + HW;

	logic [lbs_pkg::LUMA_W-1:0] mem [DEPTH];

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] position_q;

	logic [WW-1:0] width_eff;
	logic [HW-1:0] height_eff;
	logic [PW-1:0] area;
	logic [AW-1:0] last_pos;
	logic          at_end;
	logic          accept;

	logic          s1_valid_q;
	logic          op_s1;
	logic [7:0]    blue_s1;
	logic [7:0]    green_s1;
	logic [7:0]    red_s1;
	logic [AW-1:0] addr_s1;
	logic          end_s1;

	logic                         s2_valid_q;
	logic                         op_s2;
	logic [lbs_pkg::LUMA_W-1:0]   luma_s2;
	logic [lbs_pkg::LUMA_W-1:0]   bg_s2;
	logic                         end_s2;

	logic                              s2_take;
	logic                              adv_s1;
	logic [lbs_pkg::LUMA_SUM_W-1:0]    luma_sum;
	logic [lbs_pkg::LUMA_W-1:0]        luma_s1;
	logic                              mem_we;
	logic [AW-1:0]                     mem_addr;
	logic [lbs_pkg::LUMA_W-1:0]        mem_wdata;
	logic                              mem_re;

	// frame size clamped to 1..max, last raster position of the frame
	always_comb begin
		if (cfg.frame_width == '0)
			width_eff = WW'(1);
		else if (32'(cfg.frame_width) > MAX_WIDTH)
			width_eff = WW'(MAX_WIDTH);
		else
			width_eff = WW'(cfg.frame_width);
		if (cfg.frame_height == '0)
			height_eff = HW'(1);
		else if (32'(cfg.frame_height) > MAX_HEIGHT)
			height_eff = HW'(MAX_HEIGHT);
		else
			height_eff = HW'(cfg.frame_height);
		area     = PW'(width_eff) * PW'(height_eff);
		last_pos = AW'(area - PW'(1));
		at_end   = (position_q >= last_pos);
	end

	// pipeline handshake
	assign s2_take  = !s2_valid_q || item_ready;
	assign adv_s1   = s1_valid_q && s2_take;
	assign in_ready = !clearing_q && (!s1_valid_q || adv_s1);
	assign accept   = in_valid && in_ready;

	// store clearing pass after reset, raster position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			position_q <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(DEPTH - 1))
					clearing_q <= 1'b0;
			end
			if (accept)
				position_q <= at_end ? '0 : position_q + AW'(1);
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (adv_s1)
			s1_valid_q <= 1'b0;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= in_op;
			blue_s1  <= in_blue;
			green_s1 <= in_green;
			red_s1   <= in_red;
			addr_s1  <= position_q;
			end_s1   <= at_end;
		end
	end

	// luma from constant weights, top byte of the weighted sum
	assign luma_sum = lbs_pkg::LUMA_SUM_W'(lbs_pkg::COEF_R * lbs_pkg::LUMA_SUM_W'(red_s1))
		+ lbs_pkg::LUMA_SUM_W'(lbs_pkg::COEF_G * lbs_pkg::LUMA_SUM_W'(green_s1))
		+ lbs_pkg::LUMA_SUM_W'(lbs_pkg::COEF_B * lbs_pkg::LUMA_SUM_W'(blue_s1));
	assign luma_s1 = luma_sum[lbs_pkg::LUMA_SUM_W-1 -: lbs_pkg::LUMA_W];

	// store port: clearing writes, load writes, detect reads
	always_comb begin
		mem_we    = clearing_q || (adv_s1 && op_s1 == lbs_pkg::OP_LOAD);
		mem_re    = adv_s1 && op_s1 == lbs_pkg::OP_DETECT;
		mem_addr  = clearing_q ? clr_addr_q : addr_s1;
		mem_wdata = clearing_q ? '0 : luma_s1;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (mem_re)
			bg_s2 <= mem[mem_addr];
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid_q <= 1'b0;
		else if (adv_s1)
			s2_valid_q <= 1'b1;
		else if (item_ready)
			s2_valid_q <= 1'b0;
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			op_s2   <= op_s1;
			luma_s2 <= luma_s1;
			end_s2  <= end_s1;
		end
	end

	// word toward the queue; background byte only matters on detect
	assign item_valid     = s2_valid_q;
	assign item.op        = op_s2;
	assign item.luma      = luma_s2;
	assign item.bg        = bg_s2;
	assign item.frame_end = end_s2;

endmodule

### design/lbs_fifo.sv
// short queue between the front and back parts
module lbs_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  lbs_pkg::lbs_item_t  push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output lbs_pkg::lbs_item_t  pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lbs_pkg::lbs_item_t slots [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slots[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push)
			slots[wr_ptr_q] <= push_item;
	end

endmodule

### design/lbs_back.sv
// back part: threshold compare, per-frame tallies and output register
module lbs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lbs_pkg::lbs_cfg_t   cfg,
	input  logic                item_valid,
	output logic                item_ready,
	input  lbs_pkg::lbs_item_t  item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_moving,
	output logic [7:0]          out_luma,
	output logic [19:0]         out_detections,
	output logic                out_frame_end,
	output logic [31:0]         out_frames_done
);

	logic [lbs_pkg::TALLY_W-1:0]  tally_q;
	logic [lbs_pkg::FRAMES_W-1:0] frames_q;
	logic                         out_valid_q;
	logic                         pop;
	logic [lbs_pkg::LUMA_W-1:0]   diff;
	logic                         moving;
	logic [lbs_pkg::TALLY_W-1:0]  tally_next;
	logic [lbs_pkg::FRAMES_W-1:0] frames_next;

	assign item_ready = !out_valid_q || out_ready;
	assign pop        = item_valid && item_ready;

	// luma difference against background, saturating tally, frame count
	always_comb begin
		diff   = (item.luma > item.bg) ? item.luma - item.bg : item.bg - item.luma;
		moving = (item.op == lbs_pkg::OP_DETECT) && (diff > cfg.threshold);
		if (moving && tally_q != lbs_pkg::TALLY_MAX)
			tally_next = tally_q + lbs_pkg::TALLY_W'(1);
		else
			tally_next = tally_q;
		if (item.frame_end && item.op == lbs_pkg::OP_DETECT)
			frames_next = frames_q + lbs_pkg::FRAMES_W'(1);
		else
			frames_next = frames_q;
	end

	// tally state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			frames_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				tally_q  <= item.frame_end ? '0 : tally_next;
				frames_q <= frames_next;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (pop) begin
			out_moving      <= moving;
			out_luma        <= item.luma;
			out_detections  <= tally_next;
			out_frame_end   <= item.frame_end;
			out_frames_done <= frames_next;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/lbs_checker.sv
// port-level checks of the luma background subtraction block and their binding
`include "luma_background_subtraction_macros.svh"

module lbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast
);

	// a stalled output word holds
	`LBS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

	// a moving pixel is always counted in its frame tally
	`LBS_ASSERT_NOW(a_moving_counted, clk, arst_n, m_tvalid && m_tdata[0], m_tdata[28:9] != 20'd0, "moving pixel with zero frame tally")

	// fill bits above the last field stay zero
	`LBS_ASSERT_NOW(a_fill_zero, clk, arst_n, m_tvalid, m_tdata[63:61] == 3'b000, "nonzero fill bits in output word")

endmodule

bind luma_background_subtraction lbs_checker u_lbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
